>>> hdl/pru_pkg.sv
`timescale 1ns / 1ps

package pru_pkg;

   // fixed field widths
   localparam int PIX_W  = 32;
   localparam int RATE_W = 5;
   localparam int DIM_W  = 13;
   localparam int COL_W  = 12;
   localparam int IDX_W  = 2;

   // height limit of the output image
   localparam int MAX_HEIGHT = 4096;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // register indexes
   localparam logic [IDX_W-1:0] CFG_RATE       = 2'd0;
   localparam logic [IDX_W-1:0] CFG_OUT_WIDTH  = 2'd1;
   localparam logic [IDX_W-1:0] CFG_OUT_HEIGHT = 2'd2;

   // action codes
   localparam logic ACT_LIVE   = 1'b0;
   localparam logic ACT_REPLAY = 1'b1;

   typedef struct packed {
      logic             action;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic             last_copy;
      logic             row_done;
      logic             frame_done;
   } rsp_type;

   // one classified word waiting for the back end
   typedef struct packed {
      logic [PIX_W-1:0]  value;
      logic [RATE_W-1:0] count;
      logic              ends_row;
      logic              ends_frame;
   } job_type;

endpackage

>>> hdl/pru_ram.sv
`timescale 1ns / 1ps

module pru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> hdl/pru_front.sv
`timescale 1ns / 1ps

module pru_front #(
   parameter int PIXEL_BITS = 32,
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_RATE   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  pru_pkg::req_type            req_data,
   output logic                        req_stall,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pru_pkg::IDX_W-1:0]   csr_index,
   input  logic [pru_pkg::DIM_W-1:0]   csr_data,
   input  logic [pru_pkg::QCNT_W-1:0]  queue_count,
   output logic                        push,
   output pru_pkg::job_type            push_job
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   // effective configuration, clamped when written
   logic [pru_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [pru_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [pru_pkg::DIM_W-1:0]  height_ff, height_in;

   // frame position
   logic [pru_pkg::DIM_W-1:0]  col_ff, col_in;
   logic [pru_pkg::COL_W-1:0]  src_ff, src_in;
   logic [pru_pkg::DIM_W-1:0]  row_ff, row_in;
   logic [pru_pkg::RATE_W-1:0] phase_ff, phase_in;
   logic                       replay_ff, replay_in;

   // second stage, holds the word while the line store read completes
   logic                       b_valid_ff;
   logic                       b_replay_ff;
   logic [PIXEL_BITS-1:0]      b_pixel_ff;
   logic [pru_pkg::RATE_W-1:0] b_count_ff;
   logic                       b_ends_row_ff;
   logic                       b_ends_frame_ff;

   logic                       take;
   logic                       match;
   logic                       is_replay;
   logic                       cfg_wr;
   logic [pru_pkg::DIM_W-1:0]  remain;
   logic                       fits;
   logic [pru_pkg::RATE_W-1:0] count;
   logic                       ends_frame;
   logic [pru_pkg::RATE_W-1:0] phase_next;
   logic [PIXEL_BITS-1:0]      store_rd;
   logic [PIXEL_BITS-1:0]      store_wr;

   // room check covers the word still in the second stage
   assign req_stall = (queue_count + pru_pkg::QCNT_W'(b_valid_ff))
                      >= pru_pkg::QCNT_W'(pru_pkg::QUEUE_DEPTH);
   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;

   // classify the incoming word
   assign take      = req_valid && !req_stall;
   assign is_replay = (req_data.action == pru_pkg::ACT_REPLAY);
   assign match     = take && (is_replay == replay_ff);

   // copies for this word, clipped at the row end
   assign remain     = width_ff - col_ff;
   assign fits       = remain <= pru_pkg::DIM_W'(rate_ff);
   assign count      = fits ? remain[pru_pkg::RATE_W-1:0] : rate_ff;
   assign ends_frame = fits && (({1'b0, row_ff} + 14'd1) >= {1'b0, height_ff});
   assign phase_next = phase_ff + 5'd1;

   // clamp register writes
   always_comb begin
      rate_in = csr_data[pru_pkg::RATE_W-1:0];
      if (rate_in == '0) begin
         rate_in = pru_pkg::RATE_W'(1);
      end else if (rate_in > MAX_RATE) begin
         rate_in = pru_pkg::RATE_W'(MAX_RATE);
      end
      width_in = csr_data;
      if (width_in == '0) begin
         width_in = pru_pkg::DIM_W'(1);
      end else if (width_in > MAX_WIDTH) begin
         width_in = pru_pkg::DIM_W'(MAX_WIDTH);
      end
      height_in = csr_data;
      if (height_in == '0) begin
         height_in = pru_pkg::DIM_W'(1);
      end else if (height_in > pru_pkg::MAX_HEIGHT) begin
         height_in = pru_pkg::DIM_W'(pru_pkg::MAX_HEIGHT);
      end
   end

   // next frame position
   always_comb begin
      col_in    = col_ff;
      src_in    = src_ff;
      row_in    = row_ff;
      phase_in  = phase_ff;
      replay_in = replay_ff;
      if (cfg_wr) begin
         if (csr_index == pru_pkg::CFG_RATE || csr_index == pru_pkg::CFG_OUT_WIDTH
             || csr_index == pru_pkg::CFG_OUT_HEIGHT) begin
            col_in    = '0;
            src_in    = '0;
            row_in    = '0;
            phase_in  = '0;
            replay_in = 1'b0;
         end
      end else if (match) begin
         col_in = col_ff + pru_pkg::DIM_W'(count);
         src_in = src_ff + 12'd1;
         if (fits) begin
            col_in = '0;
            src_in = '0;
            if (ends_frame) begin
               row_in    = '0;
               phase_in  = '0;
               replay_in = 1'b0;
            end else begin
               row_in = row_ff + 13'd1;
               if (phase_next >= rate_ff) begin
                  phase_in  = '0;
                  replay_in = 1'b0;
               end else begin
                  phase_in  = phase_next;
                  replay_in = 1'b1;
               end
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= pru_pkg::RATE_W'(1);
         width_ff   <= pru_pkg::DIM_W'(1);
         height_ff  <= pru_pkg::DIM_W'(1);
         col_ff     <= '0;
         src_ff     <= '0;
         row_ff     <= '0;
         phase_ff   <= '0;
         replay_ff  <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            case (csr_index)
               pru_pkg::CFG_RATE:       rate_ff   <= rate_in;
               pru_pkg::CFG_OUT_WIDTH:  width_ff  <= width_in;
               pru_pkg::CFG_OUT_HEIGHT: height_ff <= height_in;
               default: ;
            endcase
         end
         col_ff     <= col_in;
         src_ff     <= src_in;
         row_ff     <= row_in;
         phase_ff   <= phase_in;
         replay_ff  <= replay_in;
         b_valid_ff <= match && !cfg_wr;
      end
   end

   // second stage payload
   always_ff @(posedge clock) begin
      if (match) begin
         b_replay_ff     <= is_replay;
         b_pixel_ff      <= store_wr;
         b_count_ff      <= count;
         b_ends_row_ff   <= fits;
         b_ends_frame_ff <= ends_frame;
      end
   end

   // line store: live words write, replay words read; the column is always
   // below the clamped width, so it fits the store
   assign store_wr = PIXEL_BITS'(req_data.pixel);

   pru_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (match && !is_replay),
      .wr_addr (ADDR_W'(src_ff)),
      .wr_data (store_wr),
      .rd_en   (match && is_replay),
      .rd_addr (ADDR_W'(src_ff)),
      .rd_data (store_rd)
   );

   // hand the word to the queue
   assign push                = b_valid_ff;
   assign push_job.value      = b_replay_ff ? pru_pkg::PIX_W'(store_rd)
                                            : pru_pkg::PIX_W'(b_pixel_ff);
   assign push_job.count      = b_count_ff;
   assign push_job.ends_row   = b_ends_row_ff;
   assign push_job.ends_frame = b_ends_frame_ff;

   // a push never meets a full queue
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (queue_count < pru_pkg::QCNT_W'(pru_pkg::QUEUE_DEPTH)))
      else $error("push into full queue");

   // the output column stays inside the row
   assert property (@(posedge clock) disable iff (reset) col_ff < width_ff)
      else $error("column past row end");

   // a classified word always carries at least one copy
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_count_ff != '0))
      else $error("word without copies");

endmodule

>>> hdl/pru_queue.sv
`timescale 1ns / 1ps

module pru_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  pru_pkg::job_type            push_job,
   input  logic                        pop,
   output pru_pkg::job_type            head_job,
   output logic                        not_empty,
   output logic [pru_pkg::QCNT_W-1:0]  count
);

   pru_pkg::job_type                entries_ff [pru_pkg::QUEUE_DEPTH];
   logic [pru_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pru_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pru_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign count     = count_ff;
   assign not_empty = (count_ff != '0);
   assign head_job  = entries_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + pru_pkg::QCNT_W'(push) - pru_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   // fill level never exceeds the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pru_pkg::QCNT_W'(pru_pkg::QUEUE_DEPTH))
      else $error("queue overflow");

   // no pop from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue underflow");

endmodule

>>> hdl/pru_back.sv
`timescale 1ns / 1ps

module pru_back (
   input  logic             clock,
   input  logic             reset,
   input  pru_pkg::job_type head_job,
   input  logic             not_empty,
   output logic             pop,
   output logic             rsp_valid,
   output pru_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   logic                       rsp_valid_ff;
   pru_pkg::rsp_type           rsp_data_ff;
   logic [pru_pkg::RATE_W-1:0] copy_ff, copy_in;
   logic                       load;
   logic                       last;

   // output register free, or being taken this cycle
   assign load = !rsp_valid_ff || !rsp_stall;
   assign last = ({1'b0, copy_ff} + 6'd1) == {1'b0, head_job.count};
   assign pop  = load && not_empty && last;

   assign copy_in = last ? '0 : copy_ff + 5'd1;

   // copy counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         copy_ff      <= '0;
      end else if (load) begin
         rsp_valid_ff <= not_empty;
         if (not_empty) begin
            copy_ff <= copy_in;
         end
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (load && not_empty) begin
         rsp_data_ff.out_pixel  <= head_job.value;
         rsp_data_ff.last_copy  <= last;
         rsp_data_ff.row_done   <= last && head_job.ends_row;
         rsp_data_ff.frame_done <= last && head_job.ends_frame;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // frame end implies row end and last copy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_done) |->
      (rsp_data_ff.row_done && rsp_data_ff.last_copy))
      else $error("frame end without row end");

   // copy index stays below the word's copy count
   assert property (@(posedge clock) disable iff (reset)
      not_empty |-> (copy_ff < head_job.count))
      else $error("copy index out of range");

endmodule

>>> hdl/pixel_replication_upscaler.sv
`timescale 1ns / 1ps

// channel  direction  handshake           payload
// req      in         req_valid/req_stall req_data (action, pixel)
// rsp      out        rsp_valid/rsp_stall rsp_data (out_pixel, last_copy, row_done, frame_done)
// csr      in         csr_valid/csr_ready csr_index, csr_data
//
// one word is taken per cycle while the four-deep queue has room
// each word of the kind the row expects gives min(rate, copies left in the row) results,
// one per cycle while rsp_stall is low, so the sustained pace is set by the copy counter in the back end
// a taken word passes through the second stage register and the queue to the output register
// reset is synchronous; the line store has no reset and no clearing pass
// rsp_stall holds the output register and, once the queue fills, req_stall

module pixel_replication_upscaler #(
   parameter int PIXEL_BITS = 32,
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_RATE   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  pru_pkg::req_type          req_data,
   output logic                      req_stall,
   output logic                      rsp_valid,
   output pru_pkg::rsp_type          rsp_data,
   input  logic                      rsp_stall,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [pru_pkg::IDX_W-1:0] csr_index,
   input  logic [pru_pkg::DIM_W-1:0] csr_data
);

   logic                       push;
   pru_pkg::job_type           push_job;
   logic                       pop;
   pru_pkg::job_type           head_job;
   logic                       not_empty;
   logic [pru_pkg::QCNT_W-1:0] queue_count;

   // front end: classify, track position, line store
   pru_front #(
      .PIXEL_BITS (PIXEL_BITS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RATE   (MAX_RATE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_count (queue_count),
      .push        (push),
      .push_job    (push_job)
   );

   // queue between the two halves
   pru_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (not_empty),
      .count     (queue_count)
   );

   // back end: emit the copies
   pru_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import pru_pkg::*;

   localparam int LINE_DEPTH    = 4096;
   localparam int RATE_CAP      = 16;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 80;
   localparam int CYCLE_LIMIT   = 1000000;

   // register index outside the list, written to show it has no effect
   localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

   // predicts the replicated copies of each accepted word and checks them in order
   class copy_ledger;
      int unsigned rate_reg, width_reg, height_reg;
      logic [PIX_W-1:0] row_memory [LINE_DEPTH];
      int unsigned col_pos, src_col, rows_done, group_row;
      bit replay_row;
      rsp_type pending[$];
      int unsigned errors;

      function new();
         rate_reg = 1;
         width_reg = 1;
         height_reg = 1;
         errors = 0;
         restart();
      endfunction

      function void restart();
         col_pos = 0;
         src_col = 0;
         rows_done = 0;
         group_row = 0;
         replay_row = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] value);
         if (idx == CFG_RATE) rate_reg = value[RATE_W-1:0];
         else if (idx == CFG_OUT_WIDTH) width_reg = value;
         else if (idx == CFG_OUT_HEIGHT) height_reg = value;
         else return;
         restart();
      endfunction

      function int unsigned outstanding();
         return pending.size();
      endfunction

      // note an accepted word and queue the copies it should give
      function void take_word(req_type word);
         int unsigned r, w, h, n, k;
         logic [PIX_W-1:0] value;
         bit ends_row, ends_frame;
         rsp_type copy;
         r = (rate_reg == 0) ? 1 : ((rate_reg > RATE_CAP) ? RATE_CAP : rate_reg);
         w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
         h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
         // a word of the wrong kind for this row is dropped
         if ((word.action == ACT_REPLAY) != replay_row) return;
         if (word.action == ACT_LIVE) begin
            value = word.pixel;
            row_memory[src_col] = value;
         end else begin
            value = row_memory[src_col];
         end
         n = w - col_pos;
         if (n > r) n = r;
         ends_row = (col_pos + n >= w);
         ends_frame = ends_row && (rows_done + 1 >= h);
         for (k = 0; k < n; k++) begin
            copy.out_pixel = value;
            copy.last_copy = (k + 1 == n);
            copy.row_done = (k + 1 == n) && ends_row;
            copy.frame_done = (k + 1 == n) && ends_frame;
            pending.push_back(copy);
         end
         col_pos += n;
         src_col = (src_col + 1) % LINE_DEPTH;
         // row and frame bookkeeping
         if (ends_row) begin
            if (ends_frame) begin
               restart();
            end else begin
               col_pos = 0;
               src_col = 0;
               rows_done++;
               group_row++;
               if (group_row >= r) begin
                  group_row = 0;
                  replay_row = 0;
               end else begin
                  replay_row = 1;
               end
            end
         end
      endfunction

      // compare one output copy with the oldest prediction
      function void match_copy(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("copy with nothing predicted: out_pixel %h", got.out_pixel);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.out_pixel !== want.out_pixel) begin
            $error("out_pixel: expected %h, actual %h", want.out_pixel, got.out_pixel);
            errors++;
         end
         if (got.last_copy !== want.last_copy) begin
            $error("last_copy: expected %b, actual %b", want.last_copy, got.last_copy);
            errors++;
         end
         if (got.row_done !== want.row_done) begin
            $error("row_done: expected %b, actual %b", want.row_done, got.row_done);
            errors++;
         end
         if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %b, actual %b", want.frame_done, got.frame_done);
            errors++;
         end
      endfunction

      function void close();
         if (pending.size() != 0) begin
            $error("%0d predicted copies never arrived", pending.size());
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   req_type req_data = '0;
   logic req_stall;
   logic rsp_valid;
   rsp_type rsp_data;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0] csr_data = '0;

   copy_ledger ledger;
   int unsigned sender_odds = 0;
   int unsigned stall_odds = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   bit calm = 0;
   bit pause_owed = 1;
   int unsigned random_count = 0;

   pixel_replication_upscaler DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // receiver stalls in bursts, started at random by stall_odds
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(1, 11) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // check every copy taken by the receiver
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.match_copy(rsp_data);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic put_word(input logic act, input logic [PIX_W-1:0] pix);
      req_type word;
      word.action = act;
      word.pixel = pix;
      // sender gap before the word
      if (!calm && sender_odds != 0 && $urandom_range(0, sender_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (req_stall);
      ledger.take_word(word);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      ledger.write_reg(idx, value);
   endtask

   // hold the sender until every predicted copy is out
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   // drained, plus time for dropped words still in flight
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly the word the row expects, now and then the wrong kind
   task automatic random_word();
      logic act;
      act = ledger.replay_row ? ACT_REPLAY : ACT_LIVE;
      if ($urandom_range(0, 9) == 0) act = ~act;
      put_word(act, $urandom);
   endtask

   task automatic run_setting(input logic [DIM_W-1:0] rate, input logic [DIM_W-1:0] width,
                              input logic [DIM_W-1:0] height, input int unsigned count);
      int unsigned i;
      sender_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      write_reg(CFG_RATE, rate);
      write_reg(CFG_OUT_WIDTH, width);
      write_reg(CFG_OUT_HEIGHT, height);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, DIM_W'($urandom));
      csr_valid <= 1'b0;
      for (i = 0; i < count; i++) begin
         if (i == count / 2 && (pause_owed || $urandom_range(0, 3) == 0)) begin
            drain();
            pause_owed = 0;
         end
         random_word();
      end
      settle();
   endtask

   initial begin
      int unsigned i, n;
      logic [DIM_W-1:0] rate, width, height;
      ledger = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset values: one copy per live word, each ending the frame
      sender_odds = 3;
      stall_odds = 4;
      put_word(ACT_LIVE, '0);
      put_word(ACT_REPLAY, '1);
      put_word(ACT_LIVE, '1);
      settle();

      // rate 3 over width 7 clips the last copy group, height 4 ends on a live row
      write_reg(CFG_RATE, 3);
      write_reg(CFG_OUT_WIDTH, 7);
      write_reg(CFG_OUT_HEIGHT, 4);
      csr_valid <= 1'b0;
      put_word(ACT_LIVE, 32'h0000_0000);
      put_word(ACT_LIVE, 32'hFFFF_FFFF);
      put_word(ACT_LIVE, 32'h5A5A_A5A5);
      settle();
      // spare index must not restart the frame
      write_reg(CFG_UNUSED, '1);
      csr_valid <= 1'b0;
      for (i = 0; i < 2; i++) begin
         put_word(ACT_LIVE, $urandom);
         repeat (3) put_word(ACT_REPLAY, $urandom);
      end
      put_word(ACT_REPLAY, $urandom);
      repeat (3) put_word(ACT_LIVE, $urandom);
      repeat (2) put_word(ACT_LIVE, $urandom);
      settle();

      // extreme settings: zeros, top rate, saturated rate, width and height registers
      run_setting(16, 20, 3, 20);
      run_setting(0, 0, 0, 8);
      run_setting(31, 8191, 8191, 100);
      run_setting(17, 1, 2, 10);

      // random settings, mostly small images
      while (random_count < RANDOM_ITEMS) begin
         rate = ($urandom_range(0, 4) == 0) ? DIM_W'($urandom_range(0, 31))
                                            : DIM_W'($urandom_range(1, 5));
         width = ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 24));
         height = DIM_W'($urandom_range(0, 10));
         n = $urandom_range(15, 50);
         run_setting(rate, width, height, n);
         random_count += n;
         calm = (random_count + 30 >= RANDOM_ITEMS);
      end

      settle();
      ledger.close();
      if (ledger.errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> pixel_replication_upscaler.f
hdl/pru_pkg.sv
hdl/pru_ram.sv
hdl/pru_front.sv
hdl/pru_queue.sv
hdl/pru_back.sv
hdl/pixel_replication_upscaler.sv
tb/tb.sv
